>>> hdl/mrcv_pkg.sv
// Shared types, constants and codes for the mesh route candidate unit.
package mrcv_pkg;

  // Sizes of the mesh and of the virtual channel space.
  localparam int MAX_SCALE   = 16;
  localparam int MAX_VCS     = 8;
  localparam int NODE_W      = 8;
  localparam int SCALE_W     = 5;
  localparam int VCS_W       = 4;
  localparam int VC_W        = 3;
  localparam int ROW_W       = $clog2(MAX_SCALE);
  localparam int THR_W       = SCALE_W + ROW_W;
  localparam int KK_W        = 2 * SCALE_W;
  localparam int NUM_SEG     = 4;
  localparam int SEG_IDX_W   = $clog2(NUM_SEG);
  localparam int QUEUE_DEPTH = 4;
  localparam int CFG_IDX_W   = 8;
  localparam int CFG_DATA_W  = 5;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROUTING_MODE = 8'd0,
    REG_MESH_SCALE   = 8'd1,
    REG_VC_COUNT     = 8'd2
  } cfg_reg_t;

  // Routing modes.
  typedef enum logic [1:0] {
    MODE_XY           = 2'd0,
    MODE_NFR          = 2'd1,
    MODE_NFR_ADAPTIVE = 2'd2,
    MODE_UNKNOWN      = 2'd3
  } mode_t;

  // Output port codes.
  typedef enum logic [1:0] {
    PORT_XNEG = 2'd0,
    PORT_XPOS = 2'd1,
    PORT_YNEG = 2'd2,
    PORT_YPOS = 2'd3
  } port_t;

  // What kind of result list a request produces.
  typedef enum logic [1:0] {
    KIND_ROUTE   = 2'd0,
    KIND_ARRIVED = 2'd1,
    KIND_ERROR   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [NODE_W-1:0] cur_node;
    logic [NODE_W-1:0] dst_node;
  } in_req_t;

  typedef struct packed {
    logic [1:0]      out_port;
    logic [VC_W-1:0] vc_index;
    logic            last_candidate;
    logic            at_destination;
    logic            route_error;
  } out_rsp_t;

  typedef struct packed {
    mode_t              mode;
    logic [SCALE_W-1:0] scale;
    logic [VCS_W-1:0]   vcs;
  } cfg_t;

  // One run of candidates: VCs lo up to hi-1 on one port.
  typedef struct packed {
    port_t            port;
    logic [VC_W-1:0]  lo;
    logic [VCS_W-1:0] hi;
  } seg_t;

  // Classified request as it travels from the front to the back.
  typedef struct packed {
    kind_t                     kind;
    logic [NUM_SEG-1:0]        seg_en;
    seg_t [NUM_SEG-1:0]        seg;
  } desc_t;

endpackage

>>> hdl/mrcv_front.sv
// Front end: accepts requests, locates both nodes and builds the candidate descriptor.
module mrcv_front (
  input  logic            clk,
  input  logic            rst_n,
  input  mrcv_pkg::cfg_t  cfg,
  input  logic            in_valid,
  output logic            in_stall,
  input  mrcv_pkg::in_req_t in_data,
  output logic            q_push,
  output mrcv_pkg::desc_t q_data,
  input  logic            q_full
);
  import mrcv_pkg::*;

  // Row thermometer: bit j is set when the id lies at or past row j.
  function automatic logic [MAX_SCALE-1:1] row_therm(input logic [NODE_W-1:0] id,
                                                     input logic [SCALE_W-1:0] k);
    logic [MAX_SCALE-1:1] t;
    t = '0;
    for (int j = 1; j < MAX_SCALE; j++) begin
      t[j] = THR_W'(id) >= (THR_W'(k) * THR_W'(j));
    end
    return t;
  endfunction

  // Id of the first node in the row that the thermometer points at.
  function automatic logic [THR_W-1:0] row_base(input logic [MAX_SCALE-1:1] t,
                                                input logic [SCALE_W-1:0] k);
    logic [THR_W-1:0] b;
    b = '0;
    for (int j = 1; j < MAX_SCALE; j++) begin
      if (t[j]) begin
        b = THR_W'(k) * THR_W'(j);
      end
    end
    return b;
  endfunction

  logic                 a_valid_r, a_valid_nxt;
  logic [NODE_W-1:0]    a_cur_r, a_dst_r;
  logic [MAX_SCALE-1:1] a_tcur_r, a_tdst_r;
  logic                 a_err_r, a_arr_r;
  logic                 a_load;
  logic [KK_W-1:0]      kk;
  logic                 err;
  logic [NODE_W-1:0]    x_cur, x_dst;
  logic                 xn, xp, yn, yp, neg;
  logic [VCS_W-1:0]     v, vm1;
  logic                 multi;

  // Stage A holds its request while the queue is full.
  assign in_stall = a_valid_r & q_full;
  assign a_load   = ~in_stall;
  assign q_push   = a_valid_r & ~q_full;

  // Range check against the configured mesh.
  always_comb begin
    kk  = KK_W'(cfg.scale) * KK_W'(cfg.scale);
    err = (cfg.mode == MODE_UNKNOWN) || (cfg.scale < SCALE_W'(2)) ||
          (cfg.scale > SCALE_W'(MAX_SCALE)) ||
          (KK_W'(in_data.cur_node) >= kk) ||
          (KK_W'(in_data.dst_node) >= kk);
  end

  always_comb begin
    a_valid_nxt = a_load ? in_valid : a_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_cur_r  <= in_data.cur_node;
      a_dst_r  <= in_data.dst_node;
      a_tcur_r <= row_therm(in_data.cur_node, cfg.scale);
      a_tdst_r <= row_therm(in_data.dst_node, cfg.scale);
      a_err_r  <= err;
      a_arr_r  <= in_data.cur_node == in_data.dst_node;
    end
  end

  // Column of each node and the productive directions.
  always_comb begin
    x_cur = NODE_W'(THR_W'(a_cur_r) - row_base(a_tcur_r, cfg.scale));
    x_dst = NODE_W'(THR_W'(a_dst_r) - row_base(a_tdst_r, cfg.scale));
    xn    = x_dst < x_cur;
    xp    = x_dst > x_cur;
    yn    = a_tdst_r < a_tcur_r;
    yp    = a_tdst_r > a_tcur_r;
    neg   = xn | yn;
  end

  // Effective VC count, clamped to 1..MAX_VCS.
  always_comb begin
    if (cfg.vcs == VCS_W'(0)) begin
      v = VCS_W'(1);
    end else if (cfg.vcs > VCS_W'(MAX_VCS)) begin
      v = VCS_W'(MAX_VCS);
    end else begin
      v = cfg.vcs;
    end
    vm1   = v - VCS_W'(1);
    multi = v > VCS_W'(1);
  end

  // Candidate runs for each routing mode.
  always_comb begin
    q_data = '0;
    priority if (a_err_r) begin
      q_data.kind = KIND_ERROR;
    end else if (a_arr_r) begin
      q_data.kind = KIND_ARRIVED;
    end else begin
      q_data.kind = KIND_ROUTE;
      unique case (cfg.mode)
        MODE_XY: begin
          q_data.seg_en[0] = 1'b1;
          q_data.seg[0].hi = v;
          priority if (xn) begin
            q_data.seg[0].port = PORT_XNEG;
          end else if (xp) begin
            q_data.seg[0].port = PORT_XPOS;
          end else if (yn) begin
            q_data.seg[0].port = PORT_YNEG;
          end else begin
            q_data.seg[0].port = PORT_YPOS;
          end
        end
        MODE_NFR: begin
          q_data.seg[0].hi   = v;
          q_data.seg[1].hi   = v;
          q_data.seg[0].port = neg ? PORT_XNEG : PORT_XPOS;
          q_data.seg[1].port = neg ? PORT_YNEG : PORT_YPOS;
          q_data.seg_en[0]   = neg ? xn : xp;
          q_data.seg_en[1]   = neg ? yn : yp;
        end
        MODE_NFR_ADAPTIVE: begin
          // Adaptive VCs on each productive port, then the escape VC.
          q_data.seg[0].hi   = vm1;
          q_data.seg[1].hi   = vm1;
          q_data.seg[0].port = xn ? PORT_XNEG : PORT_XPOS;
          q_data.seg[1].port = yn ? PORT_YNEG : PORT_YPOS;
          q_data.seg_en[0]   = (xn | xp) & multi;
          q_data.seg_en[1]   = (yn | yp) & multi;
          q_data.seg[2].lo   = VC_W'(vm1);
          q_data.seg[3].lo   = VC_W'(vm1);
          q_data.seg[2].hi   = v;
          q_data.seg[3].hi   = v;
          q_data.seg[2].port = neg ? PORT_XNEG : PORT_XPOS;
          q_data.seg[3].port = neg ? PORT_YNEG : PORT_YPOS;
          q_data.seg_en[2]   = neg ? xn : xp;
          q_data.seg_en[3]   = neg ? yn : yp;
        end
        default: begin
          q_data.kind = KIND_ERROR;
        end
      endcase
    end
  end

endmodule

>>> hdl/mrcv_queue.sv
// Short descriptor queue between the front end and the back end.
module mrcv_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  mrcv_pkg::desc_t push_data,
  output logic            full,
  input  logic            pop,
  output mrcv_pkg::desc_t head,
  output logic            head_valid
);
  import mrcv_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  desc_t            entries_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]   count_r, count_nxt;

  assign full       = count_r == (PTR_W+1)'(QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = entries_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (PTR_W+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PTR_W+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

>>> hdl/mrcv_back.sv
// Back end: walks a descriptor, emitting one candidate per cycle unless the output stalls.
module mrcv_back (
  input  logic            clk,
  input  logic            rst_n,
  input  mrcv_pkg::desc_t q_head,
  input  logic            q_valid,
  output logic            q_pop,
  output logic            out_valid,
  input  logic            out_stall,
  output mrcv_pkg::out_rsp_t out_data
);
  import mrcv_pkg::*;

  // Index of the lowest enabled run.
  function automatic logic [SEG_IDX_W-1:0] first_set(input logic [NUM_SEG-1:0] m);
    logic [SEG_IDX_W-1:0] r;
    r = '0;
    for (int i = NUM_SEG - 1; i >= 0; i--) begin
      if (m[i]) begin
        r = SEG_IDX_W'(i);
      end
    end
    return r;
  endfunction

  logic               w_valid_r, w_valid_nxt;
  kind_t              w_kind_r, w_kind_nxt;
  logic [NUM_SEG-1:0] w_en_r, w_en_nxt;
  seg_t [NUM_SEG-1:0] w_seg_r, w_seg_nxt;
  logic [VC_W-1:0]    w_vc_r, w_vc_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_rsp_t           out_data_r, out_data_nxt;

  logic [SEG_IDX_W-1:0] cur_idx;
  seg_t                 cur_seg;
  logic                 seg_done;
  logic [NUM_SEG-1:0]   rest_en;
  logic                 out_load, emit, last, item_done;
  out_rsp_t             rsp;

  // Current candidate of the working descriptor.
  always_comb begin
    cur_idx  = first_set(w_en_r);
    cur_seg  = w_seg_r[cur_idx];
    seg_done = VCS_W'(w_vc_r) == (cur_seg.hi - VCS_W'(1));
    rest_en  = w_en_r & ~(NUM_SEG'(1) << cur_idx);
    rsp      = '0;
    unique case (w_kind_r)
      KIND_ROUTE: begin
        last         = seg_done && (rest_en == '0);
        rsp.out_port = cur_seg.port;
        rsp.vc_index = w_vc_r;
      end
      KIND_ARRIVED: begin
        last               = 1'b1;
        rsp.at_destination = 1'b1;
      end
      KIND_ERROR: begin
        last            = 1'b1;
        rsp.route_error = 1'b1;
      end
      default: begin
        last = 1'b1;
      end
    endcase
    rsp.last_candidate = last;
  end

  // Handshake between the working descriptor, the queue and the output register.
  always_comb begin
    out_load  = ~out_valid_r | ~out_stall;
    emit      = w_valid_r & out_load;
    item_done = emit & last;
    q_pop     = q_valid & (~w_valid_r | item_done);
  end

  // Working descriptor update.
  always_comb begin
    w_valid_nxt = w_valid_r;
    w_kind_nxt  = w_kind_r;
    w_en_nxt    = w_en_r;
    w_seg_nxt   = w_seg_r;
    w_vc_nxt    = w_vc_r;
    priority if (q_pop) begin
      w_valid_nxt = 1'b1;
      w_kind_nxt  = q_head.kind;
      w_en_nxt    = q_head.seg_en;
      w_seg_nxt   = q_head.seg;
      w_vc_nxt    = q_head.seg[first_set(q_head.seg_en)].lo;
    end else if (item_done) begin
      w_valid_nxt = 1'b0;
    end else if (emit) begin
      if (seg_done) begin
        w_en_nxt = rest_en;
        w_vc_nxt = w_seg_r[first_set(rest_en)].lo;
      end else begin
        w_vc_nxt = w_vc_r + VC_W'(1);
      end
    end
  end

  // Output register.
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (out_load) begin
      out_valid_nxt = emit;
      out_data_nxt  = rsp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      w_valid_r   <= w_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_kind_r   <= w_kind_nxt;
    w_en_r     <= w_en_nxt;
    w_seg_r    <= w_seg_nxt;
    w_vc_r     <= w_vc_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> hdl/mesh_route_candidate_vcs_unit.sv
// Top level of the mesh route candidate unit: configuration registers, front, queue and back.
//
//   Channel   Signals                          Moves
//   in        in_valid / in_stall / in_data    one route request (current, destination)
//   out       out_valid / out_stall / out_data one candidate (port, VC, flags)
//   cfg       cfg_valid / cfg_ready / index    one register write, always ready
//
// An accepted request is held in the front end register, then waits in a four-entry
// queue and passes through the back end's working register to the output register.
// The back end emits one candidate per cycle while the output is not stalled; a request
// has one candidate for an error or arrival, up to twice the VC count otherwise.
// Requests are accepted every cycle while the queue has room.
// Synchronous reset restores the register defaults and empties the pipeline.
// A stall on the output holds the output register; the queue then absorbs requests.
module mesh_route_candidate_vcs_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mrcv_pkg::in_req_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mrcv_pkg::out_rsp_t                 out_data,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [mrcv_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mrcv_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import mrcv_pkg::*;

  cfg_t  cfg_r, cfg_nxt;
  logic  q_push, q_full, q_pop, q_valid;
  desc_t q_data, q_head;

  assign cfg_ready = 1'b1;

  // Register write decode.
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_ROUTING_MODE: cfg_nxt.mode  = mode_t'(cfg_data[1:0]);
        REG_MESH_SCALE:   cfg_nxt.scale = cfg_data[SCALE_W-1:0];
        REG_VC_COUNT:     cfg_nxt.vcs   = cfg_data[VCS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode  <= MODE_XY;
      cfg_r.scale <= SCALE_W'(4);
      cfg_r.vcs   <= VCS_W'(2);
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  mrcv_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_push   (q_push),
    .q_data   (q_data),
    .q_full   (q_full)
  );

  mrcv_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_data  (q_data),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head),
    .head_valid (q_valid)
  );

  mrcv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_head    (q_head),
    .q_valid   (q_valid),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

>>> tb/tb_mesh_route_candidate_vcs_unit.sv
// Testbench for the mesh route candidate unit: directed and random route requests, self-checked.
`timescale 1ns / 100ps

module tb_mesh_route_candidate_vcs_unit;
  import mrcv_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned SETTLE_CYCLES  = 20;
  localparam int unsigned MAX_GAP        = 4;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_req_t               in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_rsp_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Our copy of the configuration registers, at their reset values.
  mode_t              routing_mode_reg = MODE_XY;
  logic [SCALE_W-1:0] mesh_scale_reg   = SCALE_W'(4);
  logic [VCS_W-1:0]   vc_count_reg     = VCS_W'(2);

  // Candidates still owed by the block, oldest first.
  out_rsp_t    pending_candidates[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles    = 0;
  int unsigned hold_left      = 0;
  bit          sender_pauses   = 1'b1;
  bit          receiver_pauses = 1'b1;
  out_rsp_t    oldest;

  mesh_route_candidate_vcs_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // 2 ns clock.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Append one candidate to the end of the owed list.
  function automatic void owe_candidate(out_rsp_t cand);
    pending_candidates.insert(pending_candidates.size(), cand);
  endfunction

  // Queue the VCs lo up to hi-1 on one port as ordinary candidates.
  function automatic void offer_vcs(port_t port, int unsigned lo, int unsigned hi);
    out_rsp_t cand;
    cand = '0;
    cand.out_port = port;
    for (int unsigned vc = lo; vc < hi; vc++) begin
      cand.vc_index = VC_W'(vc);
      owe_candidate(cand);
    end
  endfunction

  // Work out the candidate list for one request under the current registers.
  function automatic void predict_candidates(in_req_t req);
    int unsigned side;
    int unsigned vcs;
    int unsigned cur_x, cur_y, dst_x, dst_y;
    bit          xn, xp, yn, yp;
    out_rsp_t    tail;
    side = 32'(mesh_scale_reg);
    vcs  = 32'(vc_count_reg);
    if (vcs == 0) vcs = 1;
    if (vcs > MAX_VCS) vcs = MAX_VCS;
    tail = '0;
    if (routing_mode_reg == MODE_UNKNOWN || side < 2 || side > MAX_SCALE ||
        req.cur_node >= side * side || req.dst_node >= side * side) begin
      tail.route_error = 1'b1;
      owe_candidate(tail);
    end else if (req.cur_node == req.dst_node) begin
      tail.at_destination = 1'b1;
      owe_candidate(tail);
    end else begin
      cur_x = req.cur_node % side;
      cur_y = req.cur_node / side;
      dst_x = req.dst_node % side;
      dst_y = req.dst_node / side;
      xn = dst_x < cur_x;
      xp = dst_x > cur_x;
      yn = dst_y < cur_y;
      yp = dst_y > cur_y;
      case (routing_mode_reg)
        MODE_XY: begin
          if (xn) offer_vcs(PORT_XNEG, 0, vcs);
          else if (xp) offer_vcs(PORT_XPOS, 0, vcs);
          else if (yn) offer_vcs(PORT_YNEG, 0, vcs);
          else if (yp) offer_vcs(PORT_YPOS, 0, vcs);
        end
        MODE_NFR: begin
          // Negative moves take priority; positive ports only when none is needed.
          if (xn || yn) begin
            if (xn) offer_vcs(PORT_XNEG, 0, vcs);
            if (yn) offer_vcs(PORT_YNEG, 0, vcs);
          end else begin
            if (xp) offer_vcs(PORT_XPOS, 0, vcs);
            if (yp) offer_vcs(PORT_YPOS, 0, vcs);
          end
        end
        default: begin
          // Adaptive VCs on every productive port, then the top VC as escape.
          if (xn) offer_vcs(PORT_XNEG, 0, vcs - 1);
          else if (xp) offer_vcs(PORT_XPOS, 0, vcs - 1);
          if (yn) offer_vcs(PORT_YNEG, 0, vcs - 1);
          else if (yp) offer_vcs(PORT_YPOS, 0, vcs - 1);
          if (xn || yn) begin
            if (xn) offer_vcs(PORT_XNEG, vcs - 1, vcs);
            if (yn) offer_vcs(PORT_YNEG, vcs - 1, vcs);
          end else begin
            if (xp) offer_vcs(PORT_XPOS, vcs - 1, vcs);
            if (yp) offer_vcs(PORT_YPOS, vcs - 1, vcs);
          end
        end
      endcase
    end
    // The final candidate of the request carries the last flag.
    tail = pending_candidates.pop_back();
    tail.last_candidate = 1'b1;
    owe_candidate(tail);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_count++;
    end
  endfunction

  // Receiver: check each candidate against the oldest expectation, then maybe stall.
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left = 0;
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_candidates.size() == 0) begin
          $error("unexpected candidate: port %0d vc %0d", out_data.out_port,
                 out_data.vc_index);
          mismatch_count++;
        end else begin
          oldest = pending_candidates.pop_front();
          check_field("out_port", oldest.out_port, out_data.out_port);
          check_field("vc_index", oldest.vc_index, out_data.vc_index);
          check_field("last_candidate", oldest.last_candidate, out_data.last_candidate);
          check_field("at_destination", oldest.at_destination, out_data.at_destination);
          check_field("route_error", oldest.route_error, out_data.route_error);
        end
        hold_left = receiver_pauses ? $urandom_range(0, MAX_GAP) : 0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which no channel moves anything.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb_mesh_route_candidate_vcs_unit: FAIL");
        $finish;
      end
    end
  end

  // Send one route request after a random gap and predict its candidates.
  task automatic send_route_request(logic [NODE_W-1:0] cur, logic [NODE_W-1:0] dst);
    int unsigned gap;
    in_req_t     req;
    gap = sender_pauses ? $urandom_range(0, MAX_GAP) : 0;
    req.cur_node = cur;
    req.dst_node = dst;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_candidates(req);
  endtask

  // Hold off new requests until every owed candidate has arrived.
  task automatic wait_for_all_candidates();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_candidates.size() != 0);
  endtask

  // One register write; valid stays up for the next write.
  task automatic write_register(cfg_reg_t index, logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (index)
      REG_ROUTING_MODE: routing_mode_reg = mode_t'(value[1:0]);
      REG_MESH_SCALE:   mesh_scale_reg   = value;
      REG_VC_COUNT:     vc_count_reg     = value[VCS_W-1:0];
      default: ;
    endcase
  endtask

  // Rewrite all three registers; only called with the block drained.
  task automatic configure(logic [CFG_DATA_W-1:0] mode_raw, logic [CFG_DATA_W-1:0] scale_raw,
                           logic [CFG_DATA_W-1:0] vcs_raw);
    write_register(REG_ROUTING_MODE, mode_raw);
    write_register(REG_MESH_SCALE, scale_raw);
    write_register(REG_VC_COUNT, vcs_raw);
    cfg_valid <= 1'b0;
  endtask

  // Reset values: XY routing on a 4x4 mesh with two VCs.
  task automatic test_reset_defaults();
    send_route_request(8'd5, 8'd5);
    send_route_request(8'd16, 8'd3);
    send_route_request(8'd0, 8'd15);
    send_route_request(8'd15, 8'd0);
  endtask

  // XY routing on the largest mesh with the most VCs, each direction once.
  task automatic test_xy_mode();
    wait_for_all_candidates();
    configure(MODE_XY, 5'd16, 5'd8);
    send_route_request(8'd0, 8'd255);
    send_route_request(8'd255, 8'd0);
    send_route_request(8'd0, 8'd240);
    send_route_request(8'd240, 8'd0);
  endtask

  // Negative-first: both negative ports, both positive ports, and mixed moves.
  task automatic test_negative_first();
    wait_for_all_candidates();
    configure(MODE_NFR, 5'd16, 5'd8);
    send_route_request(8'd255, 8'd0);
    send_route_request(8'd0, 8'd255);
    send_route_request(8'd15, 8'd240);
    send_route_request(8'd240, 8'd15);
  endtask

  // Adaptive mode, including a single VC and VC counts that get clamped.
  task automatic test_adaptive_escape();
    wait_for_all_candidates();
    configure(MODE_NFR_ADAPTIVE, 5'd16, 5'd8);
    send_route_request(8'd255, 8'd0);
    send_route_request(8'd0, 8'd255);
    send_route_request(8'd15, 8'd240);
    wait_for_all_candidates();
    configure(MODE_NFR_ADAPTIVE, 5'd16, 5'd1);
    send_route_request(8'd0, 8'd255);
    wait_for_all_candidates();
    configure(MODE_NFR_ADAPTIVE, 5'd2, 5'd0);
    send_route_request(8'd3, 8'd0);
    wait_for_all_candidates();
    configure(MODE_NFR_ADAPTIVE, 5'd16, 5'd31);
    send_route_request(8'd17, 8'd34);
  endtask

  // Unknown mode, bad mesh sizes, node ids just off the mesh.
  task automatic test_route_errors();
    wait_for_all_candidates();
    configure(5'd31, 5'd16, 5'd2);
    send_route_request(8'd0, 8'd1);
    wait_for_all_candidates();
    configure(MODE_XY, 5'd1, 5'd2);
    send_route_request(8'd0, 8'd0);
    wait_for_all_candidates();
    configure(MODE_NFR, 5'd0, 5'd2);
    send_route_request(8'd0, 8'd1);
    wait_for_all_candidates();
    configure(MODE_NFR_ADAPTIVE, 5'd17, 5'd2);
    send_route_request(8'd0, 8'd1);
    wait_for_all_candidates();
    configure(MODE_XY, 5'd31, 5'd2);
    send_route_request(8'd0, 8'd1);
    wait_for_all_candidates();
    configure(MODE_XY, 5'd2, 5'd3);
    send_route_request(8'd4, 8'd0);
    send_route_request(8'd0, 8'd4);
    send_route_request(8'd4, 8'd4);
    send_route_request(8'd3, 8'd3);
  endtask

  // One random setting, then random requests, mostly on the mesh.
  task automatic run_random_phase(int unsigned count);
    logic [CFG_DATA_W-1:0] mode_raw, scale_raw, vcs_raw;
    logic [NODE_W-1:0]     cur, dst;
    int unsigned           side;
    int unsigned           pick;
    wait_for_all_candidates();
    mode_raw = CFG_DATA_W'($urandom_range(0, 31));
    if ($urandom_range(0, 9) != 0 && mode_raw[1:0] == MODE_UNKNOWN)
      mode_raw[1:0] = 2'($urandom_range(0, 2));
    pick = $urandom_range(0, 9);
    if (pick == 0) scale_raw = CFG_DATA_W'($urandom_range(0, 1));
    else if (pick == 1) scale_raw = CFG_DATA_W'($urandom_range(17, 31));
    else if (pick < 5) scale_raw = 5'd16;
    else scale_raw = CFG_DATA_W'($urandom_range(2, 16));
    vcs_raw = ($urandom_range(0, 3) != 0) ? CFG_DATA_W'($urandom_range(1, 8)) :
                                            CFG_DATA_W'($urandom_range(0, 31));
    configure(mode_raw, scale_raw, vcs_raw);
    sender_pauses   = $urandom_range(0, 3) != 0;
    receiver_pauses = $urandom_range(0, 3) != 0;
    side = 32'(scale_raw);
    for (int unsigned n = 0; n < count; n++) begin
      pick = $urandom_range(0, 19);
      if (side < 2 || side > MAX_SCALE || pick == 0) begin
        cur = NODE_W'($urandom_range(0, 255));
        dst = NODE_W'($urandom_range(0, 255));
      end else begin
        cur = NODE_W'($urandom_range(0, side * side - 1));
        dst = (pick < 3) ? cur : NODE_W'($urandom_range(0, side * side - 1));
      end
      send_route_request(cur, dst);
      // Now and then let the block run dry before going on.
      if (n % 16 == 15 && $urandom_range(0, 1) == 1)
        wait_for_all_candidates();
    end
  endtask

  initial begin
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= REG_ROUTING_MODE;
    cfg_data  <= '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_xy_mode();
    test_negative_first();
    test_adaptive_escape();
    test_route_errors();
    repeat (12) run_random_phase(33);

    wait_for_all_candidates();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_candidates.size() == 0) begin
      $display("tb_mesh_route_candidate_vcs_unit: PASS");
    end else begin
      $display("tb_mesh_route_candidate_vcs_unit: FAIL");
    end
    $finish;
  end

endmodule
